// File: design/mieu_pkg.sv
`default_nettype none

package mieu_pkg;

   localparam int WORD_W  = 32;
   localparam int FUNC_W  = 5;
   localparam int SHAMT_W = 5;
   localparam int CNT_W   = $clog2(WORD_W);

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [FUNC_W-1:0]  func_type;
   typedef logic [SHAMT_W-1:0] shamt_type;

   localparam func_type FN_ADD   = 5'd0;
   localparam func_type FN_ADDU  = 5'd1;
   localparam func_type FN_SUB   = 5'd2;
   localparam func_type FN_SUBU  = 5'd3;
   localparam func_type FN_AND   = 5'd4;
   localparam func_type FN_OR    = 5'd5;
   localparam func_type FN_XOR   = 5'd6;
   localparam func_type FN_NOR   = 5'd7;
   localparam func_type FN_SLT   = 5'd8;
   localparam func_type FN_SLTU  = 5'd9;
   localparam func_type FN_SLL   = 5'd10;
   localparam func_type FN_SRL   = 5'd11;
   localparam func_type FN_SRA   = 5'd12;
   localparam func_type FN_SLLV  = 5'd13;
   localparam func_type FN_SRLV  = 5'd14;
   localparam func_type FN_SRAV  = 5'd15;
   localparam func_type FN_LUI   = 5'd16;
   localparam func_type FN_MULT  = 5'd17;
   localparam func_type FN_MULTU = 5'd18;
   localparam func_type FN_DIV   = 5'd19;
   localparam func_type FN_DIVU  = 5'd20;
   localparam func_type FN_MFHI  = 5'd21;
   localparam func_type FN_MFLO  = 5'd22;
   localparam func_type FN_MTHI  = 5'd23;
   localparam func_type FN_MTLO  = 5'd24;

   // command to the multiply/divide unit
   typedef struct packed {
      logic start;
      logic divide;
      logic signed_op;
   } md_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

endpackage

`default_nettype wire

// File: design/mieu_if.sv
`default_nettype none

interface mieu_req_if;
   import mieu_pkg::*;

   logic      valid;
   logic      ready;
   func_type  func;
   word_type  operand_a;
   word_type  operand_b;
   shamt_type shift_amount;

   modport source (output valid, output func, output operand_a, output operand_b,
                   output shift_amount, input ready);
   modport sink (input valid, input func, input operand_a, input operand_b,
                 input shift_amount, output ready);
endinterface

interface mieu_rsp_if;
   import mieu_pkg::*;

   logic     valid;
   logic     ready;
   word_type result_value;
   logic     writes_register;
   logic     overflow_trap;

   modport source (output valid, output result_value, output writes_register,
                   output overflow_trap, input ready);
   modport sink (input valid, input result_value, input writes_register,
                 input overflow_trap, output ready);
endinterface

`default_nettype wire

// File: design/mips_integer_execute_unit_core.sv
// MIPS R3000 integer execute unit. One request beat gives one response beat,
// in order. ALU, shift, lui and HI/LO move operations answer at once:
// the response register is loaded on the accepting edge, and a new request is
// taken as soon as that register is free or being emptied. mult, multu, div
// and divu answer in the same way (no register write), but start the serial
// multiply/divide unit, which runs one bit per cycle through shift registers:
// the accepting edge loads the operand magnitudes, then the iteration steps
// and a sign-correction step follow; HI and LO are updated at the end of the
// sign-correction step, and no new request is taken until then. Divide by
// zero and the most negative value over minus one fall out of the restoring
// divide with the usual R3000 results. HI and LO reset to zero.
`default_nettype none

module mips_integer_execute_unit_core (
   input  logic clock,
   input  logic reset,
   mieu_req_if.sink   req_chan,
   mieu_rsp_if.source rsp_chan
);
   import mieu_pkg::*;

   word_type    hi_word_ff, hi_word_in;
   word_type    lo_word_ff, lo_word_in;
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_value_ff, rsp_value_in;
   logic        rsp_wr_ff, rsp_wr_in;
   logic        rsp_ovf_ff, rsp_ovf_in;

   md_cmd_type  md_cmd;
   md_stat_type md_stat;
   word_type    md_hi, md_lo;

   logic        accept;
   word_type    a, b;
   word_type    sum, diff;
   shamt_type   vsa;
   word_type    res;
   logic        wr, ovf;

   mieu_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .op_a  (req_chan.operand_a),
      .op_b  (req_chan.operand_b),
      .stat  (md_stat),
      .hi_o  (md_hi),
      .lo_o  (md_lo)
   );

   assign req_chan.ready = !md_stat.busy && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      a    = req_chan.operand_a;
      b    = req_chan.operand_b;
      sum  = a + b;
      diff = a - b;
      vsa  = a[SHAMT_W-1:0];
      res  = '0;
      wr   = 1'b1;
      ovf  = 1'b0;
      md_cmd.start     = 1'b0;
      md_cmd.divide    = 1'b0;
      md_cmd.signed_op = 1'b0;

      case (req_chan.func)
         FN_ADD: begin
            if (~(a[WORD_W-1] ^ b[WORD_W-1]) & (a[WORD_W-1] ^ sum[WORD_W-1])) begin
               wr  = 1'b0;
               ovf = 1'b1;
            end else begin
               res = sum;
            end
         end
         FN_ADDU: res = sum;
         FN_SUB: begin
            if ((a[WORD_W-1] ^ b[WORD_W-1]) & (a[WORD_W-1] ^ diff[WORD_W-1])) begin
               wr  = 1'b0;
               ovf = 1'b1;
            end else begin
               res = diff;
            end
         end
         FN_SUBU: res = diff;
         FN_AND:  res = a & b;
         FN_OR:   res = a | b;
         FN_XOR:  res = a ^ b;
         FN_NOR:  res = ~(a | b);
         FN_SLT:  res = WORD_W'($signed(a) < $signed(b));
         FN_SLTU: res = WORD_W'(a < b);
         FN_SLL:  res = b << req_chan.shift_amount;
         FN_SRL:  res = b >> req_chan.shift_amount;
         FN_SRA:  res = word_type'($signed(b) >>> req_chan.shift_amount);
         FN_SLLV: res = b << vsa;
         FN_SRLV: res = b >> vsa;
         FN_SRAV: res = word_type'($signed(b) >>> vsa);
         FN_LUI:  res = {b[WORD_W/2-1:0], {(WORD_W/2){1'b0}}};
         FN_MULT: begin
            wr = 1'b0;
            md_cmd.start     = accept;
            md_cmd.signed_op = 1'b1;
         end
         FN_MULTU: begin
            wr = 1'b0;
            md_cmd.start = accept;
         end
         FN_DIV: begin
            wr = 1'b0;
            md_cmd.start     = accept;
            md_cmd.divide    = 1'b1;
            md_cmd.signed_op = 1'b1;
         end
         FN_DIVU: begin
            wr = 1'b0;
            md_cmd.start  = accept;
            md_cmd.divide = 1'b1;
         end
         FN_MFHI: res = hi_word_ff;
         FN_MFLO: res = lo_word_ff;
         FN_MTHI: wr = 1'b0;
         FN_MTLO: wr = 1'b0;
         default: wr = 1'b0;
      endcase
   end

   always_comb begin
      hi_word_in = hi_word_ff;
      lo_word_in = lo_word_ff;
      if (md_stat.done) begin
         hi_word_in = md_hi;
         lo_word_in = md_lo;
      end else if (accept && req_chan.func == FN_MTHI) begin
         hi_word_in = req_chan.operand_a;
      end else if (accept && req_chan.func == FN_MTLO) begin
         lo_word_in = req_chan.operand_a;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_wr_in    = rsp_wr_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res;
         rsp_wr_in    = wr;
         rsp_ovf_in   = ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_word_ff   <= '0;
         lo_word_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hi_word_ff   <= hi_word_in;
         lo_word_ff   <= lo_word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_wr_ff    <= rsp_wr_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.result_value    = rsp_value_ff;
   assign rsp_chan.writes_register = rsp_wr_ff;
   assign rsp_chan.overflow_trap   = rsp_ovf_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      !(md_cmd.start && md_stat.busy))
      else $error("multiply/divide started while busy");

   a_beat_answered: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat produced no response");

   a_hold_while_busy: assert property (@(posedge clock) disable iff (reset)
      md_stat.busy |-> !req_chan.ready)
      else $error("request taken while HI/LO pending");

   a_trap_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_wr_ff && rsp_ovf_ff))
      else $error("overflow response marked as register write");

endmodule

`default_nettype wire

// File: design/mieu_muldiv.sv
`default_nettype none

module mieu_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  mieu_pkg::md_cmd_type cmd,
   input  mieu_pkg::word_type   op_a,
   input  mieu_pkg::word_type   op_b,
   output mieu_pkg::md_stat_type stat,
   output mieu_pkg::word_type   hi_o,
   output mieu_pkg::word_type   lo_o
);
   import mieu_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIX  = 2'd2;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   word_type         hi_ff, hi_in;     // product high half / partial remainder
   word_type         lo_ff, lo_in;     // multiplier / dividend-quotient shifter
   word_type         dsr_ff, dsr_in;   // multiplicand or divisor magnitude
   logic             divide_ff, divide_in;
   logic             neg_lo_ff, neg_lo_in;
   logic             neg_hi_ff, neg_hi_in;

   logic             a_neg, b_neg;
   word_type         a_mag, b_mag;
   logic [WORD_W:0]  mul_sum;
   logic [WORD_W:0]  div_trial;
   logic [2*WORD_W-1:0] prod_neg;

   always_comb begin
      a_neg     = cmd.signed_op & op_a[WORD_W-1];
      b_neg     = cmd.signed_op & op_b[WORD_W-1];
      a_mag     = a_neg ? (~op_a + 1'b1) : op_a;
      b_mag     = b_neg ? (~op_b + 1'b1) : op_b;
      mul_sum   = {1'b0, hi_ff} + {1'b0, dsr_ff};
      div_trial = {hi_ff, lo_ff[WORD_W-1]} - {1'b0, dsr_ff};
      prod_neg  = ~{hi_ff, lo_ff} + 1'b1;

      state_in  = state_ff;
      count_in  = count_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      dsr_in    = dsr_ff;
      divide_in = divide_ff;
      neg_lo_in = neg_lo_ff;
      neg_hi_in = neg_hi_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in  = ST_RUN;
               count_in  = '0;
               hi_in     = '0;
               lo_in     = a_mag;
               dsr_in    = b_mag;
               divide_in = cmd.divide;
               neg_lo_in = a_neg ^ b_neg;
               // remainder follows the dividend; product sign covers both halves
               neg_hi_in = cmd.divide ? a_neg : (a_neg ^ b_neg);
            end
         end
         ST_RUN: begin
            if (divide_ff) begin
               if (!div_trial[WORD_W]) begin
                  hi_in = div_trial[WORD_W-1:0];
                  lo_in = {lo_ff[WORD_W-2:0], 1'b1};
               end else begin
                  hi_in = {hi_ff[WORD_W-2:0], lo_ff[WORD_W-1]};
                  lo_in = {lo_ff[WORD_W-2:0], 1'b0};
               end
            end else if (lo_ff[0]) begin
               {hi_in, lo_in} = {mul_sum, lo_ff[WORD_W-1:1]};
            end else begin
               {hi_in, lo_in} = {1'b0, hi_ff, lo_ff[WORD_W-1:1]};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff  <= count_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      dsr_ff    <= dsr_in;
      divide_ff <= divide_in;
      neg_lo_ff <= neg_lo_in;
      neg_hi_ff <= neg_hi_in;
   end

   // sign correction is applied on the way out, in the done beat
   always_comb begin
      if (divide_ff) begin
         hi_o = neg_hi_ff ? (~hi_ff + 1'b1) : hi_ff;
         lo_o = neg_lo_ff ? (~lo_ff + 1'b1) : lo_ff;
      end else if (neg_lo_ff) begin
         hi_o = prod_neg[2*WORD_W-1:WORD_W];
         lo_o = prod_neg[WORD_W-1:0];
      end else begin
         hi_o = hi_ff;
         lo_o = lo_ff;
      end
      stat.busy = (state_ff != ST_IDLE);
      stat.done = (state_ff == ST_FIX);
   end

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> !stat.done)
      else $error("done held for more than one cycle");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && !stat.busy) |=> (stat.busy && !stat.done))
      else $error("start did not begin an iteration");

   a_fix_after_run: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> ($past(state_ff) == ST_RUN && $past(count_ff) == CNT_LAST))
      else $error("done without a full iteration");

endmodule

`default_nettype wire
